// File: hdl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// types and constants shared by the serial frame receiver modules
// ----------------------------------------------------------------------------
package sfr_pkg;

    // configuration register indexes
    localparam logic CFG_TIMEOUT_RELOAD = 1'b0;
    localparam logic CFG_START_BYTE     = 1'b1;

    // register reset values
    localparam logic [7:0] TIMEOUT_RELOAD_RST = 8'd20;
    localparam logic [7:0] START_BYTE_RST     = 8'hAA;
    localparam logic [7:0] CHECK_SEED         = 8'hFF;

    // command fields sized for the largest supported buffer (64 bytes)
    localparam int CMD_IDX_W = 6;
    localparam int CMD_LEN_W = 7;

    // result status codes
    typedef enum logic [2:0] {
        ST_FRAME_BYTE   = 3'd0,
        ST_CHECKSUM_ERR = 3'd1,
        ST_BAD_START    = 3'd2,
        ST_TIMEOUT      = 3'd3,
        ST_LEN_OVERFLOW = 3'd4
    } status_t;

    // front to back command kinds
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_EMIT   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        status_t                status;
        logic [7:0]             data;
        logic [CMD_IDX_W-1:0]   idx;
        logic [CMD_LEN_W-1:0]   len;
    } cmd_t;

endpackage

// File: hdl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// accepts bytes and ticks, tracks frame state and issues back-end commands
// ----------------------------------------------------------------------------
module sfr_front #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic            cfg_addr,
    input  logic [7:0]      cfg_wdata,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tuser,
    input  logic            q_full,
    output logic            q_push,
    output sfr_pkg::cmd_t   q_cmd
);

    localparam int FW = $clog2(BUFFER_DEPTH + 1);

    logic [7:0]    reload_reg;
    logic [7:0]    start_reg;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    check_reg, check_next;
    logic [7:0]    tout_reg, tout_next;
    logic [7:0]    lenb_reg, lenb_next;

    logic          accept;
    logic [FW-1:0] fill_inc;
    logic [7:0]    chk;
    logic [7:0]    len_sel;
    logic          overflow;
    logic          complete;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign fill_inc = fill_reg + FW'(1);
    assign chk      = check_reg ^ s_tdata;
    assign len_sel  = (fill_reg == FW'(1)) ? s_tdata : lenb_reg;
    assign overflow = ({1'b0, len_sel} + 9'd1) > 9'(BUFFER_DEPTH);
    assign complete = 8'(fill_inc) > len_sel;

    always_comb begin
        fill_next  = fill_reg;
        check_next = check_reg;
        tout_next  = tout_reg;
        lenb_next  = lenb_reg;
        q_push     = 1'b0;
        q_cmd      = '{kind: sfr_pkg::CMD_WRITE, status: sfr_pkg::ST_FRAME_BYTE,
                       data: s_tdata, idx: sfr_pkg::CMD_IDX_W'(fill_reg),
                       len: sfr_pkg::CMD_LEN_W'(fill_inc)};
        if (accept) begin
            if (s_tuser) begin
                // timeout tick
                if (tout_reg != 8'd0) begin
                    tout_next = tout_reg - 8'd1;
                    if (tout_reg == 8'd1 && fill_reg != '0) begin
                        q_push       = 1'b1;
                        q_cmd.kind   = sfr_pkg::CMD_REPORT;
                        q_cmd.status = sfr_pkg::ST_TIMEOUT;
                        q_cmd.len    = sfr_pkg::CMD_LEN_W'(fill_reg);
                        fill_next    = '0;
                        check_next   = sfr_pkg::CHECK_SEED;
                    end
                end
            end else begin
                tout_next = reload_reg;
                q_push    = 1'b1;
                if (fill_reg == '0) begin
                    if (s_tdata != start_reg) begin
                        q_cmd.kind   = sfr_pkg::CMD_REPORT;
                        q_cmd.status = sfr_pkg::ST_BAD_START;
                        q_cmd.len    = sfr_pkg::CMD_LEN_W'(1);
                    end else begin
                        fill_next  = fill_inc;
                        check_next = chk;
                    end
                end else begin
                    if (fill_reg == FW'(1)) begin
                        lenb_next = s_tdata;
                    end
                    if (overflow) begin
                        q_cmd.kind   = sfr_pkg::CMD_REPORT;
                        q_cmd.status = sfr_pkg::ST_LEN_OVERFLOW;
                        q_cmd.len    = sfr_pkg::CMD_LEN_W'(2);
                        fill_next    = '0;
                        check_next   = sfr_pkg::CHECK_SEED;
                    end else if (complete) begin
                        fill_next  = '0;
                        check_next = sfr_pkg::CHECK_SEED;
                        tout_next  = 8'd0;
                        if (chk != 8'd0) begin
                            q_cmd.kind   = sfr_pkg::CMD_REPORT;
                            q_cmd.status = sfr_pkg::ST_CHECKSUM_ERR;
                        end else begin
                            q_cmd.kind = sfr_pkg::CMD_EMIT;
                        end
                    end else begin
                        fill_next  = fill_inc;
                        check_next = chk;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= sfr_pkg::TIMEOUT_RELOAD_RST;
            start_reg  <= sfr_pkg::START_BYTE_RST;
            fill_reg   <= '0;
            check_reg  <= sfr_pkg::CHECK_SEED;
            tout_reg   <= 8'd0;
            lenb_reg   <= 8'd0;
        end else begin
            if (cfg_wr_en && cfg_addr == sfr_pkg::CFG_TIMEOUT_RELOAD) begin
                reload_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_addr == sfr_pkg::CFG_START_BYTE) begin
                start_reg <= cfg_wdata;
            end
            fill_reg  <= fill_next;
            check_reg <= check_next;
            tout_reg  <= tout_next;
            lenb_reg  <= lenb_next;
        end
    end

    // fill never reaches the buffer depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) < BUFFER_DEPTH)
        else $error("fill position beyond buffer");

    // an idle timer stays idle on a tick
    a_tick_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser && tout_reg == 8'd0) |=> tout_reg == 8'd0)
        else $error("idle timeout counter moved");

    // an empty frame never produces a timeout abort
    a_no_empty_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_cmd.status == sfr_pkg::ST_TIMEOUT) |-> fill_reg != '0)
        else $error("timeout abort of an empty frame");

endmodule

// File: hdl/sfr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sfr_cmd_fifo
// two-entry command queue between the front and back ends
// ----------------------------------------------------------------------------
module sfr_cmd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sfr_pkg::cmd_t   push_cmd,
    output logic            full,
    input  logic            pop,
    output sfr_pkg::cmd_t   pop_cmd,
    output logic            empty
);

    sfr_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'((push && !full) ? 1 : 0)
                                   - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

// File: hdl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// executes commands: frame store writes, status reports and frame playback
// ----------------------------------------------------------------------------
module sfr_back #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  sfr_pkg::cmd_t   q_cmd,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [23:0]     m_tdata,
    output logic [2:0]      m_tuser,
    output logic            m_tlast
);

    localparam int IW = $clog2(BUFFER_DEPTH);

    typedef enum logic {
        BK_IDLE,
        BK_SEND
    } bk_state_t;

    logic [7:0] store [BUFFER_DEPTH];

    bk_state_t                      state_reg;
    logic [IW-1:0]                  cnt_reg;
    logic [sfr_pkg::CMD_LEN_W-1:0]  len_reg;
    logic [7:0]                     rd_data_reg;
    logic                           m_tvalid_reg;
    logic [23:0]                    m_tdata_reg;
    logic [2:0]                     m_tuser_reg;
    logic                           m_tlast_reg;

    logic                           slot_free;
    logic                           load;
    logic                           out_load;
    logic                           final_byte;
    logic [IW-1:0]                  rd_addr;
    logic                           wr_en;

    assign slot_free  = !m_tvalid_reg || m_tready;
    assign q_pop      = (state_reg == BK_IDLE) && !q_empty && slot_free;
    assign load       = (state_reg == BK_SEND) && slot_free;
    assign out_load   = load || (q_pop && q_cmd.kind == sfr_pkg::CMD_REPORT);
    assign final_byte = (sfr_pkg::CMD_LEN_W'(cnt_reg) + sfr_pkg::CMD_LEN_W'(1)) == len_reg;
    assign wr_en      = q_pop && (q_cmd.kind == sfr_pkg::CMD_WRITE
                               || q_cmd.kind == sfr_pkg::CMD_EMIT);

    // prefetch the next byte as the current one leaves
    always_comb begin
        if (state_reg == BK_SEND) begin
            rd_addr = load ? cnt_reg + IW'(1) : cnt_reg;
        end else begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[q_cmd.idx[IW-1:0]] <= q_cmd.data;
        end
        rd_data_reg <= store[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                BK_IDLE: begin
                    if (q_pop && q_cmd.kind == sfr_pkg::CMD_REPORT) begin
                        m_tdata_reg  <= {7'd0, 5'(q_cmd.len), 4'd0, 8'd0};
                        m_tuser_reg  <= q_cmd.status;
                        m_tlast_reg  <= 1'b1;
                    end else if (q_pop && q_cmd.kind == sfr_pkg::CMD_EMIT) begin
                        state_reg <= BK_SEND;
                        cnt_reg   <= '0;
                        len_reg   <= q_cmd.len;
                    end
                end
                BK_SEND: begin
                    if (load) begin
                        m_tdata_reg  <= {7'd0, 5'(len_reg), 4'(cnt_reg), rd_data_reg};
                        m_tuser_reg  <= sfr_pkg::ST_FRAME_BYTE;
                        m_tlast_reg  <= final_byte;
                        cnt_reg      <= cnt_reg + IW'(1);
                        if (final_byte) begin
                            state_reg <= BK_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= BK_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // an emit command starts playback on the next cycle
    a_emit_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_cmd.kind == sfr_pkg::CMD_EMIT) |=> state_reg == BK_SEND)
        else $error("emit did not start playback");

    // playback index stays inside the frame
    a_cnt_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_SEND |-> (sfr_pkg::CMD_LEN_W'(cnt_reg) < len_reg
                                  && len_reg >= sfr_pkg::CMD_LEN_W'(2)))
        else $error("playback index outside frame");

    // the last frame byte returns the back end to idle
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && final_byte) |=> state_reg == BK_IDLE && m_tlast_reg)
        else $error("frame end not marked");

endmodule

// File: hdl/serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver
// length-prefixed frame receiver with xor checksum and inter-byte timeout
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  s_       in         tdata[7:0] rx_byte; tuser[0] op (0 byte, 1 tick)
//  m_       out        tdata frame_byte/byte_index/frame_length; tuser status;
//                      tlast marks the final result of an input transaction
//  cfg_     in         write only: 0 timeout_reload, 1 start_byte
//
//  the front end takes one input transaction per cycle while the two-entry
//  command queue has room; each transaction yields at most one command
//  a good frame occupies the back end from its emit command, which issues
//  the first frame store read, then one byte per cycle while not stalled
//  a report or store write is done by the back end as it pops the command
//  a stalled result channel holds the back end, then fills the queue, then
//  drops s_tready; reset is synchronous, no clearing pass is needed
// ----------------------------------------------------------------------------
module serial_frame_receiver #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] frame_byte, [11:8] byte_index,
                                   // [16:12] frame_length, [23:17] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast    // last
);

    // commands from front end to queue
    logic          push;
    sfr_pkg::cmd_t push_cmd;
    logic          q_full;

    // commands from queue to back end
    logic          pop;
    sfr_pkg::cmd_t pop_cmd;
    logic          q_empty;

    // front end: byte/tick classification, frame tracking, timeout
    sfr_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (push),
        .q_cmd     (push_cmd)
    );

    // decoupling queue
    sfr_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    // back end: frame store and result generation
    sfr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_cmd    (pop_cmd),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
